/* rtl/aipt_pkg.sv */
// aipt_pkg: shared constants for the inverse affine point transform
// defaults for the value format and the configuration register indexes
// no dependencies
package aipt_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int INDEX_WIDTH       = 3;

  // configuration register indexes
  typedef enum logic [INDEX_WIDTH-1:0] {
    REG_COEF_ROW1_COL1 = 3'd0,
    REG_COEF_ROW1_COL2 = 3'd1,
    REG_COEF_ROW1_COL3 = 3'd2,
    REG_COEF_ROW2_COL1 = 3'd3,
    REG_COEF_ROW2_COL2 = 3'd4,
    REG_COEF_ROW2_COL3 = 3'd5
  } reg_index_t;

endpackage

/* rtl/affine_inverse_point_transform.sv */
// affine_inverse_point_transform: top level of the inverse 2D affine point transform
// depends on aipt_pkg and aipt_divider
//
// Usage: six coefficient registers (a11 a12 tx a21 a22 ty, signed fixed point) are
// written through cfg_write/cfg_index/cfg_data, one per cycle; the user must write
// them only while no point is in flight, as the block does not enforce it. Points
// enter on in_valid/in_ready with kind, point_x, point_y; each point gives one
// result on out_valid/out_ready with result_x, result_y, singular. There are five
// front stages (translate, multiply, subtract, magnitude, range check), one divider
// stage per quotient bit, then round and saturate. Throughput is one point per
// cycle unless out_ready stalls it, set by the fully pipelined quotient-bit stages.
// Reset clears all valid bits and loads the identity matrix. When the receiver
// stalls, results back up stage by stage; bubbles are squeezed out and in_ready
// drops only once every stage holds a point. Nothing is lost or repeated.
module affine_inverse_point_transform #(
  parameter int VALUE_WIDTH   = aipt_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = aipt_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [aipt_pkg::INDEX_WIDTH-1:0]  cfg_index,
  input  logic [VALUE_WIDTH-1:0]            cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic signed [VALUE_WIDTH-1:0]     point_x,
  input  logic signed [VALUE_WIDTH-1:0]     point_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [VALUE_WIDTH-1:0]     result_x,
  output logic signed [VALUE_WIDTH-1:0]     result_y,
  output logic                              singular
);
  import aipt_pkg::*;

  localparam int V   = VALUE_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int PW  = 2 * V + 1;       // product of coef and difference
  localparam int NSW = 2 * V + 2;       // signed numerator
  localparam int MW  = 2 * V + 1;       // numerator magnitude
  localparam int DW  = 2 * V;           // determinant magnitude
  localparam int NW  = MW + F;          // scaled numerator
  localparam int CW  = NW + DW + V;     // range check width
  localparam int TW  = 2 * (V + 1) + 5; // divider side band

  // coefficient registers
  logic signed [V-1:0] a11, a12, tx, a21, a22, ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      a11 <= V'(1) << F;
      a12 <= '0;
      tx  <= '0;
      a21 <= '0;
      a22 <= V'(1) << F;
      ty  <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_COEF_ROW1_COL1: a11 <= cfg_data;
        REG_COEF_ROW1_COL2: a12 <= cfg_data;
        REG_COEF_ROW1_COL3: tx  <= cfg_data;
        REG_COEF_ROW2_COL1: a21 <= cfg_data;
        REG_COEF_ROW2_COL2: a22 <= cfg_data;
        REG_COEF_ROW2_COL3: ty  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall chain
  logic va, vb, vc, vd, ve, vf, vg;
  logic lda, ldb, ldc, ldd, lde, ldf, ldg;
  logic div_in_ready, div_out_valid;

  assign ldg      = !vg || out_ready;
  assign ldf      = !vf || ldg;
  assign lde      = !ve || div_in_ready;
  assign ldd      = !vd || lde;
  assign ldc      = !vc || ldd;
  assign ldb      = !vb || ldc;
  assign lda      = !va || ldb;
  assign in_ready = lda;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
    end else begin
      if (lda) va <= in_valid;
      if (ldb) vb <= va;
      if (ldc) vc <= vb;
      if (ldd) vd <= vc;
      if (lde) ve <= vd;
      if (ldf) vf <= div_out_valid;
      if (ldg) vg <= vf;
    end
  end

  // stage a: translation subtracted for positions, kept one bit wider
  logic signed [V:0] dx_a, dy_a;

  always_ff @(posedge clk) begin
    if (lda) begin
      dx_a <= {point_x[V-1], point_x} - (kind ? '0 : {tx[V-1], tx});
      dy_a <= {point_y[V-1], point_y} - (kind ? '0 : {ty[V-1], ty});
    end
  end

  // stage b: all products
  logic signed [PW-1:0]  p1_b, p2_b, p3_b, p4_b;
  logic signed [DW-1:0]  q1_b, q2_b;
  logic signed [V:0]     dx_b, dy_b;
  logic signed [V:0]     a11_e, a12_e, a21_e, a22_e;

  assign a11_e = {a11[V-1], a11};
  assign a12_e = {a12[V-1], a12};
  assign a21_e = {a21[V-1], a21};
  assign a22_e = {a22[V-1], a22};

  always_ff @(posedge clk) begin
    if (ldb) begin
      p1_b <= PW'(a22_e * dx_a);
      p2_b <= PW'(a12_e * dy_a);
      p3_b <= PW'(a11_e * dy_a);
      p4_b <= PW'(a21_e * dx_a);
      q1_b <= a11 * a22;
      q2_b <= a12 * a21;
      dx_b <= dx_a;
      dy_b <= dy_a;
    end
  end

  // stage c: numerators and determinant
  logic signed [NSW-1:0] nx_c, ny_c;
  logic signed [DW:0]    det_c;
  logic signed [V:0]     dx_c, dy_c;

  always_ff @(posedge clk) begin
    if (ldc) begin
      nx_c  <= {p1_b[PW-1], p1_b} - {p2_b[PW-1], p2_b};
      ny_c  <= {p3_b[PW-1], p3_b} - {p4_b[PW-1], p4_b};
      det_c <= {q1_b[DW-1], q1_b} - {q2_b[DW-1], q2_b};
      dx_c  <= dx_b;
      dy_c  <= dy_b;
    end
  end

  // stage d: magnitudes and quotient signs
  logic [NSW-1:0] nx_neg, ny_neg;
  logic [DW:0]    det_neg;
  logic [MW-1:0]  magx_d, magy_d;
  logic [DW-1:0]  magd_d;
  logic           sx_d, sy_d, sing_d;
  logic signed [V:0] dx_d, dy_d;

  assign nx_neg  = -nx_c;
  assign ny_neg  = -ny_c;
  assign det_neg = -det_c;

  always_ff @(posedge clk) begin
    if (ldd) begin
      magx_d <= nx_c[NSW-1] ? nx_neg[MW-1:0] : nx_c[MW-1:0];
      magy_d <= ny_c[NSW-1] ? ny_neg[MW-1:0] : ny_c[MW-1:0];
      magd_d <= det_c[DW] ? det_neg[DW-1:0] : det_c[DW-1:0];
      sx_d   <= nx_c[NSW-1] ^ det_c[DW];
      sy_d   <= ny_c[NSW-1] ^ det_c[DW];
      sing_d <= (det_c == '0);
      dx_d   <= dx_c;
      dy_d   <= dy_c;
    end
  end

  // stage e: quotient range check and first partial remainder
  logic [CW-1:0] nfx, nfy, dsh, nshx, nshy;
  logic [DW-1:0] rx_e, ry_e, magd_e;
  logic [V-1:0]  lx_e, ly_e;
  logic [TW-1:0] tag_e;

  assign nfx  = CW'({magx_d, {F{1'b0}}});
  assign nfy  = CW'({magy_d, {F{1'b0}}});
  assign dsh  = CW'(magd_d) << V;
  assign nshx = nfx >> V;
  assign nshy = nfy >> V;

  always_ff @(posedge clk) begin
    if (lde) begin
      rx_e   <= nshx[DW-1:0];
      ry_e   <= nshy[DW-1:0];
      lx_e   <= nfx[V-1:0];
      ly_e   <= nfy[V-1:0];
      magd_e <= magd_d;
      tag_e  <= {sing_d, sx_d, sy_d, nfx >= dsh, nfy >= dsh, dx_d, dy_d};
    end
  end

  // quotient bits
  logic [DW-1:0] d_o, rx_o, ry_o;
  logic [V-1:0]  qx_o, qy_o;
  logic [TW-1:0] tag_o;

  aipt_divider #(
    .VALUE_WIDTH (V),
    .TAG_WIDTH   (TW)
  ) u_divider (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (ve),
    .in_ready    (div_in_ready),
    .divisor     (magd_e),
    .rem_x       (rx_e),
    .rem_y       (ry_e),
    .low_x       (lx_e),
    .low_y       (ly_e),
    .tag         (tag_e),
    .out_valid   (div_out_valid),
    .out_ready   (ldf),
    .out_divisor (d_o),
    .out_rem_x   (rx_o),
    .out_rem_y   (ry_o),
    .out_quot_x  (qx_o),
    .out_quot_y  (qy_o),
    .out_tag     (tag_o)
  );

  // stage f: round half away from zero on the magnitude
  logic [V:0]    qx_f, qy_f;
  logic [TW-1:0] tag_f;

  always_ff @(posedge clk) begin
    if (ldf) begin
      qx_f  <= {1'b0, qx_o} + (V+1)'({rx_o, 1'b0} >= {1'b0, d_o});
      qy_f  <= {1'b0, qy_o} + (V+1)'({ry_o, 1'b0} >= {1'b0, d_o});
      tag_f <= tag_o;
    end
  end

  // stage g: saturate and select the pass-through for a singular matrix
  logic              sing_f, sx_f, sy_f, ovx_f, ovy_f;
  logic signed [V:0] dx_f, dy_f;
  logic [V:0]        limx, limy, magx_g, magy_g;
  logic [V:0]        resx_neg, resy_neg;
  logic [V-1:0]      passx, passy;
  logic [V-1:0]      smax, smin;

  assign {sing_f, sx_f, sy_f, ovx_f, ovy_f, dx_f, dy_f} = tag_f;

  assign smax = {1'b0, {(V-1){1'b1}}};
  assign smin = {1'b1, {(V-1){1'b0}}};

  always_comb begin
    limx     = sx_f ? ((V+1)'(1) << (V-1)) : (((V+1)'(1) << (V-1)) - (V+1)'(1));
    limy     = sy_f ? ((V+1)'(1) << (V-1)) : (((V+1)'(1) << (V-1)) - (V+1)'(1));
    magx_g   = (ovx_f || qx_f > limx) ? limx : qx_f;
    magy_g   = (ovy_f || qy_f > limy) ? limy : qy_f;
    resx_neg = -magx_g;
    resy_neg = -magy_g;
    passx    = (dx_f[V] != dx_f[V-1]) ? (dx_f[V] ? smin : smax) : dx_f[V-1:0];
    passy    = (dy_f[V] != dy_f[V-1]) ? (dy_f[V] ? smin : smax) : dy_f[V-1:0];
  end

  always_ff @(posedge clk) begin
    if (ldg) begin
      if (sing_f) begin
        result_x <= passx;
        result_y <= passy;
      end else begin
        result_x <= sx_f ? resx_neg[V-1:0] : magx_g[V-1:0];
        result_y <= sy_f ? resy_neg[V-1:0] : magy_g[V-1:0];
      end
      singular <= sing_f;
    end
  end

  assign out_valid = vg;

endmodule

/* rtl/aipt_divider.sv */
// aipt_divider: pipelined restoring divider, one quotient bit per stage, two lanes
// sharing one divisor, with a side-band tag carried alongside
// depends on aipt_pkg for parameter defaults
module aipt_divider #(
  parameter int VALUE_WIDTH = aipt_pkg::VALUE_WIDTH_DEF,
  parameter int TAG_WIDTH   = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2*VALUE_WIDTH-1:0]   divisor,
  input  logic [2*VALUE_WIDTH-1:0]   rem_x,
  input  logic [2*VALUE_WIDTH-1:0]   rem_y,
  input  logic [VALUE_WIDTH-1:0]     low_x,
  input  logic [VALUE_WIDTH-1:0]     low_y,
  input  logic [TAG_WIDTH-1:0]       tag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2*VALUE_WIDTH-1:0]   out_divisor,
  output logic [2*VALUE_WIDTH-1:0]   out_rem_x,
  output logic [2*VALUE_WIDTH-1:0]   out_rem_y,
  output logic [VALUE_WIDTH-1:0]     out_quot_x,
  output logic [VALUE_WIDTH-1:0]     out_quot_y,
  output logic [TAG_WIDTH-1:0]       out_tag
);
  import aipt_pkg::*;

  localparam int V  = VALUE_WIDTH;
  localparam int DW = 2 * VALUE_WIDTH;

  logic [V-1:0]  v_reg;
  logic [V:0]    ld;
  logic [DW-1:0] d_reg  [V];
  logic [DW-1:0] rx_reg [V];
  logic [DW-1:0] ry_reg [V];
  logic [V-1:0]  nx_reg [V];
  logic [V-1:0]  ny_reg [V];
  logic [V-1:0]  qx_reg [V];
  logic [V-1:0]  qy_reg [V];
  logic [TAG_WIDTH-1:0] tag_reg [V];

  // stall chain: a stage loads when empty or when the next one moves
  assign ld[V]    = out_ready;
  assign in_ready = ld[0];

  for (genvar i = 0; i < V; i++) begin : g_stage
    logic                 v_in;
    logic [DW-1:0]        d_in;
    logic [DW-1:0]        rx_in;
    logic [DW-1:0]        ry_in;
    logic [V-1:0]         nx_in;
    logic [V-1:0]         ny_in;
    logic [V-1:0]         qx_in;
    logic [V-1:0]         qy_in;
    logic [TAG_WIDTH-1:0] tag_in;
    logic [DW:0]          tx;
    logic [DW:0]          ty;
    logic                 gex;
    logic                 gey;
    logic [DW:0]          sx;
    logic [DW:0]          sy;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign d_in   = divisor;
      assign rx_in  = rem_x;
      assign ry_in  = rem_y;
      assign nx_in  = low_x;
      assign ny_in  = low_y;
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign tag_in = tag;
    end else begin : g_next
      assign v_in   = v_reg[i-1];
      assign d_in   = d_reg[i-1];
      assign rx_in  = rx_reg[i-1];
      assign ry_in  = ry_reg[i-1];
      assign nx_in  = nx_reg[i-1];
      assign ny_in  = ny_reg[i-1];
      assign qx_in  = qx_reg[i-1];
      assign qy_in  = qy_reg[i-1];
      assign tag_in = tag_reg[i-1];
    end

    assign ld[i] = !v_reg[i] || ld[i+1];

    // one restoring step per lane
    assign tx  = {rx_in, nx_in[V-1]};
    assign ty  = {ry_in, ny_in[V-1]};
    assign gex = tx >= {1'b0, d_in};
    assign gey = ty >= {1'b0, d_in};
    assign sx  = tx - {1'b0, d_in};
    assign sy  = ty - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_reg[i] <= 1'b0;
      end else if (ld[i]) begin
        v_reg[i] <= v_in;
      end
      if (ld[i]) begin
        d_reg[i]   <= d_in;
        rx_reg[i]  <= gex ? sx[DW-1:0] : tx[DW-1:0];
        ry_reg[i]  <= gey ? sy[DW-1:0] : ty[DW-1:0];
        nx_reg[i]  <= {nx_in[V-2:0], 1'b0};
        ny_reg[i]  <= {ny_in[V-2:0], 1'b0};
        qx_reg[i]  <= {qx_in[V-2:0], gex};
        qy_reg[i]  <= {qy_in[V-2:0], gey};
        tag_reg[i] <= tag_in;
      end
    end
  end

  assign out_valid   = v_reg[V-1];
  assign out_divisor = d_reg[V-1];
  assign out_rem_x   = rx_reg[V-1];
  assign out_rem_y   = ry_reg[V-1];
  assign out_quot_x  = qx_reg[V-1];
  assign out_quot_y  = qy_reg[V-1];
  assign out_tag     = tag_reg[V-1];

endmodule

/* bench/aipt_checker.sv */
// aipt_checker: watches both channels of the inverse affine point transform,
// predicts each result from its own copy of the coefficients and compares
// depends on aipt_pkg for the register index type
module aipt_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  aipt_pkg::reg_index_t  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  kind,
  input  logic signed [31:0]    point_x,
  input  logic signed [31:0]    point_y,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic signed [31:0]    result_x,
  input  logic signed [31:0]    result_y,
  input  logic                  singular,
  output int                    fail_count,
  output int                    pending
);
  import aipt_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        sing;
  } mapped_point_t;

  logic signed [31:0] a11, a12, tx, a21, a22, ty;
  mapped_point_t      mapped_q[$];

  // clamp a sign/magnitude value to the Q16.16 range
  function automatic logic [31:0] clamp(input logic neg, input logic [127:0] mag);
    if (neg) begin
      clamp = (mag > 128'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
    end else begin
      clamp = (mag > 128'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
    end
  endfunction

  // rounded num * 2^16 / den, ties away from zero
  function automatic logic [31:0] fixed_div(input logic signed [127:0] num,
                                            input logic signed [127:0] den);
    logic [127:0] n, d, q, r;
    n = num[127] ? -num : num;
    d = den[127] ? -den : den;
    q = (n << 16) / d;
    r = (n << 16) % d;
    if ((r << 1) >= d) q = q + 1;
    fixed_div = clamp(num[127] ^ den[127], q);
  endfunction

  function automatic mapped_point_t inverse_map(input logic k,
                                                input logic signed [31:0] px,
                                                input logic signed [31:0] py);
    logic signed [127:0] dx, dy, det;
    mapped_point_t m;
    dx = px;
    dy = py;
    if (!k) begin
      dx = dx - tx;
      dy = dy - ty;
    end
    det = a11 * a22 - a12 * a21;
    if (det == 0) begin
      m.x = clamp(dx[127], dx[127] ? -dx : dx);
      m.y = clamp(dy[127], dy[127] ? -dy : dy);
      m.sing = 1'b1;
    end else begin
      m.x = fixed_div(a22 * dx - a12 * dy, det);
      m.y = fixed_div(a11 * dy - a21 * dx, det);
      m.sing = 1'b0;
    end
    return m;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = mapped_q.size();

  // coefficient shadow, prediction on input transfer, compare on output transfer
  always @(posedge clk) begin
    mapped_point_t w;
    if (rst) begin
      a11 <= 32'h0001_0000; a12 <= '0; tx <= '0;
      a21 <= '0; a22 <= 32'h0001_0000; ty <= '0;
      mapped_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_COEF_ROW1_COL1: a11 <= cfg_data;
          REG_COEF_ROW1_COL2: a12 <= cfg_data;
          REG_COEF_ROW1_COL3: tx  <= cfg_data;
          REG_COEF_ROW2_COL1: a21 <= cfg_data;
          REG_COEF_ROW2_COL2: a22 <= cfg_data;
          REG_COEF_ROW2_COL3: ty  <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) mapped_q.push_back(inverse_map(kind, point_x, point_y));
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          report("unexpected result_x", result_x, 'x);
        end else begin
          w = mapped_q.pop_front();
          if (result_x !== w.x) report("result_x", result_x, w.x);
          if (result_y !== w.y) report("result_y", result_y, w.y);
          if (singular !== w.sing) report("singular", singular, w.sing);
        end
      end
    end
  end
endmodule

/* bench/tb_affine_inverse_point_transform.sv */
// tb_affine_inverse_point_transform: drives points and coefficient writes into
// the inverse affine point transform and gives the verdict
// depends on aipt_pkg, aipt_checker and the block itself
module tb_affine_inverse_point_transform;
  import aipt_pkg::*;

  localparam int LATENCY_WAIT = 60;
  localparam int STALL_LIMIT  = 5000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  reg_index_t         cfg_index = REG_COEF_ROW1_COL1;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = 1'b0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] result_x, result_y;
  logic               singular;
  int                 fail_count, pending;
  int                 send_idle = 0, recv_idle = 0;
  int                 quiet_cycles = 0;

  affine_inverse_point_transform u_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .kind, .point_x, .point_y,
    .out_valid, .out_ready, .result_x, .result_y, .singular
  );

  aipt_checker u_checker (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .kind, .point_x, .point_y,
    .out_valid, .out_ready, .result_x, .result_y, .singular,
    .fail_count, .pending
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stop sending, then wait until every result is back
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_coef(input reg_index_t idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // load a full matrix a11 a12 tx a21 a22 ty while the pipe is empty
  task automatic load_matrix(input logic [31:0] c11, c12, c13, c21, c22, c23);
    drain_and_settle();
    write_coef(REG_COEF_ROW1_COL1, c11);
    write_coef(REG_COEF_ROW1_COL2, c12);
    write_coef(REG_COEF_ROW1_COL3, c13);
    write_coef(REG_COEF_ROW2_COL1, c21);
    write_coef(REG_COEF_ROW2_COL2, c22);
    write_coef(REG_COEF_ROW2_COL3, c23);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // one point transfer, with random gaps in front of it
  task automatic send_point(input logic k, input logic [31:0] x, input logic [31:0] y);
    logic taken;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    point_x  <= x;
    point_y  <= y;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0:       rand_value = $urandom;
      1:       rand_value = $urandom_range(32'h0008_0000) - 32'h0004_0000;
      2:       rand_value = {{12{$urandom_range(1) == 1}}, 20'($urandom)};
      default: rand_value = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                              : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(4))
      0:       rand_coef = $urandom;
      1:       rand_coef = 32'h0;
      2:       rand_coef = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: rand_coef = {{8{$urandom_range(1) == 1}}, 24'($urandom)};
    endcase
  endfunction

  initial begin
    logic [31:0] c11, c12, c21, c22;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity after reset, extremes of both kinds
    send_point(1'b0, 32'h7fff_ffff, 32'h8000_0000);
    send_point(1'b1, 32'h8000_0000, 32'h7fff_ffff);
    send_point(1'b0, 32'h0, 32'h0);
    send_point(1'b1, 32'hffff_ffff, 32'h0000_0001);

    // translation difference overflows one bit, result saturates
    load_matrix(32'h0001_0000, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0001_0000, 32'h8000_0000);
    send_point(1'b0, 32'h8000_0000, 32'h7fff_ffff);
    send_point(1'b0, 32'h7fff_ffff, 32'h8000_0000);
    send_point(1'b1, 32'h8000_0000, 32'h7fff_ffff);

    // zero determinant, position and direction pass through
    load_matrix(32'h0002_0000, 32'h0001_0000, 32'h7fff_ffff, 32'h0004_0000,
                32'h0002_0000, 32'h8000_0000);
    send_point(1'b0, 32'h8000_0000, 32'h7fff_ffff);
    send_point(1'b0, 32'h0001_2345, 32'hfff0_0000);
    send_point(1'b1, 32'h8000_0000, 32'h7fff_ffff);

    // extreme coefficients, tiny determinant, rounding ties
    load_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff);
    send_point(1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(1'b1, 32'h0000_0001, 32'hffff_ffff);
    load_matrix(32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 32'h0);
    send_point(1'b1, 32'h0000_0001, 32'hffff_ffff);
    send_point(1'b1, 32'h7fff_ffff, 32'h8000_0000);
    load_matrix(32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'hfffe_0000, 32'h0);
    send_point(1'b1, 32'h0000_0001, 32'h0000_0003);
    send_point(1'b1, 32'hffff_ffff, 32'hffff_fffd);

    // random phases; each phase gets a fresh matrix
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle = 66; recv_idle = 36;
      end else if (phase == 8) begin
        send_idle = 0; recv_idle = 0;
      end else if (phase == 0) begin
        send_idle = 36; recv_idle = 66;
      end
      c11 = rand_coef(); c12 = rand_coef(); c21 = rand_coef(); c22 = rand_coef();
      // every so often a singular matrix
      if (phase % 4 == 3) begin
        c11 = 32'h0;
        c12 = 32'h0;
      end
      load_matrix(c11, c12, rand_value(), c21, c22, rand_value());
      for (int n = 0; n < 158; n++) begin
        send_point($urandom_range(1), rand_value(), rand_value());
        // sender holds off until the pipe has drained
        if (n == 80) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    drain_and_settle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
